// File: hw/rtl/sdr_pkg.sv
// Shared types, widths and twiddle construction for the sliding DFT resynthesis core.
`default_nettype none

package sdr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int DIFF_W    = 17;
  localparam int BIN_W     = 32;
  localparam int TW_W      = 12;
  localparam int TW_FRAC   = 10;
  localparam int ACC_W     = 21;
  localparam int OUT_SHIFT = 5;
  localparam int ROT_RE_W  = 33;
  localparam int ROT_P_W   = 42;
  localparam int SUM_P_W   = 31;
  localparam int TAYLOR_N  = 12;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [TW_W-1:0]     twiddle_t;

  typedef struct packed {
    logic signed [BIN_W-1:0] re;
    logic signed [BIN_W-1:0] im;
  } bin_t;

  typedef struct packed {
    logic clr;
    logic vld;
  } rot_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_RUN,
    ST_FIN
  } sdr_state_t;

  // Q30 to Q10, truncated toward zero.
  function automatic twiddle_t sdr_q30_to_q10(input longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = mag >>> 20;
    return TW_W'((v < 0) ? -mag : mag);
  endfunction

  // cos or sin of quad*pi/2 + phi, phi in Q30 within the first quadrant.
  function automatic twiddle_t sdr_twiddle(input longint unsigned phi,
                                           input logic [1:0] quad,
                                           input logic want_sin);
    longint unsigned tc;
    longint unsigned ts;
    longint c0;
    longint s0;
    longint cv;
    longint sv;
    tc = 64'd1 << 30;
    ts = phi;
    c0 = 0;
    s0 = 0;
    cv = 0;
    sv = 0;
    for (int n = 0; n < TAYLOR_N; n++) begin
      if ((n & 1) != 0) begin
        c0 = c0 - $signed(tc);
        s0 = s0 - $signed(ts);
      end else begin
        c0 = c0 + $signed(tc);
        s0 = s0 + $signed(ts);
      end
      tc = (((tc * phi) >> 30) * phi) >> 30;
      tc = tc / 64'((2 * n + 1) * (2 * n + 2));
      ts = (((ts * phi) >> 30) * phi) >> 30;
      ts = ts / 64'((2 * n + 2) * (2 * n + 3));
    end
    unique case (quad)
      2'd0: begin cv = c0;  sv = s0;  end
      2'd1: begin cv = -s0; sv = c0;  end
      2'd2: begin cv = -c0; sv = -s0; end
      2'd3: begin cv = s0;  sv = -c0; end
    endcase
    return want_sin ? sdr_q30_to_q10(sv) : sdr_q30_to_q10(cv);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sdr_window.sv
// Circular sample window: one write port, registered read, zero until first wrap.
`default_nettype none

module sdr_window
  import sdr_pkg::*;
#(
  parameter int DEPTH = 50
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [$clog2(DEPTH)-1:0] ptr,
  input  wire logic                     wr_en,
  input  wire sample_t                  wr_data,
  output sample_t                       rd_data
);

  sample_t mem [DEPTH];
  sample_t rd_r;
  logic    full_r;
  logic    full_nxt;

  // Writes go in pointer order, so writing entry zero means every entry is filled.
  assign full_nxt = full_r | (wr_en & (ptr == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ptr] <= wr_data;
    end
    rd_r <= mem[ptr];
  end

  assign rd_data = full_r ? rd_r : '0;

endmodule

`default_nettype wire

// File: hw/rtl/sdr_cell.sv
// One ring cell holding a complex bin, handed to its neighbor on each shift.
`default_nettype none

module sdr_cell
  import sdr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic shift_en,
  input  wire bin_t bin_in,
  output bin_t      bin_q
);

  bin_t bin_r;
  bin_t bin_nxt;

  assign bin_nxt = shift_en ? bin_in : bin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r <= '0;
    end else begin
      bin_r <= bin_nxt;
    end
  end

  assign bin_q = bin_r;

endmodule

`default_nettype wire

// File: hw/rtl/sdr_rot.sv
// Pipelined bin update: add difference, twiddle rotation, resynthesis accumulate.
`default_nettype none

module sdr_rot
  import sdr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire rot_ctl_t ctl,
  input  wire bin_t     bin_in,
  input  wire diff_t    d,
  input  wire twiddle_t tw_cos,
  input  wire twiddle_t tw_sin,
  output bin_t          bin_out,
  output logic [ACC_W-1:0] acc
);

  // stage 1: real part plus difference
  logic                       v1_r;
  logic signed [ROT_RE_W-1:0] re1_r;
  logic signed [BIN_W-1:0]    im1_r;
  twiddle_t                   cs1_r, sn1_r;
  logic signed [ROT_RE_W-1:0] re_sum;

  // stage 2: rotation products, low bits only
  logic                      v2_r;
  logic signed [ROT_P_W-1:0] p_rc_r, p_is_r, p_rs_r, p_ic_r;
  twiddle_t                  cs2_r, sn2_r;
  logic signed [44:0]        p_rc, p_rs;
  logic signed [43:0]        p_is, p_ic;

  // stage 3: rotated bin
  logic                      v3_r;
  bin_t                      nb_r;
  twiddle_t                  cs3_r, sn3_r;
  logic signed [ROT_P_W-1:0] nr_full, ni_full;

  // stage 4: resynthesis products
  logic               v4_r;
  logic [SUM_P_W-1:0] q_c_r, q_s_r;
  logic signed [43:0] q_c, q_s;
  logic [SUM_P_W-1:0] q_sum;

  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;

  assign re_sum  = ROT_RE_W'(bin_in.re) + ROT_RE_W'(d);
  assign p_rc    = re1_r * cs1_r;
  assign p_rs    = re1_r * sn1_r;
  assign p_is    = im1_r * sn1_r;
  assign p_ic    = im1_r * cs1_r;
  assign nr_full = p_rc_r - p_is_r;
  assign ni_full = p_rs_r + p_ic_r;
  assign q_c     = nb_r.re * cs3_r;
  assign q_s     = nb_r.im * sn3_r;
  assign q_sum   = q_c_r + q_s_r;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (v4_r) begin
      acc_nxt = acc_r + q_sum[SUM_P_W-1:TW_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      v1_r  <= ctl.vld;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    re1_r  <= re_sum;
    im1_r  <= bin_in.im;
    cs1_r  <= tw_cos;
    sn1_r  <= tw_sin;
    p_rc_r <= p_rc[ROT_P_W-1:0];
    p_is_r <= p_is[ROT_P_W-1:0];
    p_rs_r <= p_rs[ROT_P_W-1:0];
    p_ic_r <= p_ic[ROT_P_W-1:0];
    cs2_r  <= cs1_r;
    sn2_r  <= sn1_r;
    nb_r.re <= nr_full[ROT_P_W-1:TW_FRAC];
    nb_r.im <= ni_full[ROT_P_W-1:TW_FRAC];
    cs3_r  <= cs2_r;
    sn3_r  <= sn2_r;
    q_c_r  <= q_c[SUM_P_W-1:0];
    q_s_r  <= q_s[SUM_P_W-1:0];
  end

  assign bin_out = nb_r;
  assign acc     = acc_r;

endmodule

`default_nettype wire

// File: hw/rtl/sliding_dft_resynthesis_core.sv
// Top level of the sliding DFT analysis and resynthesis core.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    in_sample_in   (signed 16)
//  out      output     out_valid / out_stall  out_sample_out (signed 16)
//  cfg      input      cfg_wr_en              cfg_wr_data    (bypass, 1 bit)
//
// A beat passes from acceptance through the read, difference, run and final steps to a
// valid result; the core takes no new sample until it is back in idle. The run step
// shifts the bin ring: WINDOW/2 - 1 cells plus three rotation stages make one full
// revolution, then a last run step drains the resynthesis accumulator.
// Reset is synchronous and clears bins, pointer and bypass; no clearing pass is needed.
// A stalled result holds the core in its final step; a new beat is still taken
// while the previous result waits.
`default_nettype none

module sliding_dft_resynthesis_core
  import sdr_pkg::*;
#(
  parameter int WINDOW = 50
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire sample_t in_sample_in,
  output logic         out_valid,
  input  wire logic    out_stall,
  output sample_t      out_sample_out,
  input  wire logic    cfg_wr_en,
  input  wire logic    cfg_wr_data
);

  localparam int NB    = WINDOW / 2 - 1;
  localparam int PTR_W = $clog2(WINDOW);
  localparam int IDX_W = (NB > 1) ? $clog2(NB) : 1;
  localparam int CNT_W = $clog2(NB + 4);
  localparam logic [CNT_W-1:0] NB_C      = CNT_W'(NB);
  localparam logic [CNT_W-1:0] SHIFT_END = CNT_W'(NB + 3);
  localparam logic [CNT_W-1:0] RUN_LAST  = CNT_W'(NB + 3);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(WINDOW - 1);

  sdr_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  sample_t          x_r, x_nxt;
  diff_t            d_r, d_nxt;
  logic [BIN_W-1:0] bin0_r, bin0_nxt;
  logic             bypass_r, bypass_nxt;
  logic             out_valid_r, out_valid_nxt;
  sample_t          out_data_r, out_data_nxt;

  logic       accept;
  logic       shift_en;
  logic       win_we;
  rot_ctl_t   rot_ctl;
  sample_t    old_sample;
  diff_t      d_new;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] total;
  logic [IDX_W-1:0] tw_idx;

  twiddle_t tw_cos_tab [NB];
  twiddle_t tw_sin_tab [NB];
  bin_t     cell_q  [NB];
  bin_t     cell_in [NB];
  bin_t     rot_out;

  // Twiddles for bins 1 .. NB, built at elaboration.
  for (genvar k = 0; k < NB; k++) begin : g_tw
    localparam int unsigned      BIN = k + 1;
    localparam int unsigned      QD  = (4 * BIN) / WINDOW;
    localparam int unsigned      RM  = 4 * BIN - QD * WINDOW;
    localparam longint unsigned  PHI = (HALF_PI_Q30 * RM) / WINDOW;
    assign tw_cos_tab[k] = sdr_twiddle(PHI, 2'(QD), 1'b0);
    assign tw_sin_tab[k] = sdr_twiddle(PHI, 2'(QD), 1'b1);
  end

  // Bin ring: the rotation pipeline closes the loop from cell zero to the last cell.
  for (genvar i = 0; i < NB; i++) begin : g_cell
    if (i == NB - 1) begin : g_tail
      assign cell_in[i] = rot_out;
    end else begin : g_link
      assign cell_in[i] = cell_q[i + 1];
    end
    sdr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .bin_in   (cell_in[i]),
      .bin_q    (cell_q[i])
    );
  end

  assign tw_idx = (cnt_r < NB_C) ? cnt_r[IDX_W-1:0] : '0;

  sdr_rot u_rot (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (rot_ctl),
    .bin_in  (cell_q[0]),
    .d       (d_r),
    .tw_cos  (tw_cos_tab[tw_idx]),
    .tw_sin  (tw_sin_tab[tw_idx]),
    .bin_out (rot_out),
    .acc     (acc)
  );

  sdr_window #(
    .DEPTH (WINDOW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ptr     (ptr_r),
    .wr_en   (win_we),
    .wr_data (x_r),
    .rd_data (old_sample)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign d_new    = DIFF_W'(x_r) - DIFF_W'(old_sample);
  assign total    = acc + bin0_r[ACC_W:1];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    x_nxt         = x_r;
    d_nxt         = d_r;
    bin0_nxt      = bin0_r;
    bypass_nxt    = cfg_wr_en ? cfg_wr_data : bypass_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    shift_en      = 1'b0;
    win_we        = 1'b0;
    rot_ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ptr_nxt   = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
          x_nxt     = in_sample_in;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        d_nxt       = d_new;
        bin0_nxt    = bin0_r + BIN_W'(d_new);
        win_we      = 1'b1;
        rot_ctl.clr = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_RUN;
      end
      ST_RUN: begin
        shift_en    = (cnt_r < SHIFT_END);
        rot_ctl.vld = (cnt_r < NB_C);
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == RUN_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register frees up
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = bypass_r ? x_r : total[ACC_W-1:OUT_SHIFT];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ptr_r       <= '0;
      bin0_r      <= '0;
      bypass_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      bin0_r      <= bin0_nxt;
      bypass_r    <= bypass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    d_r        <= d_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

`ifndef SYNTHESIS
  a_seq_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_READ) ##1 (state_r == ST_DIFF) ##1 (state_r == ST_RUN))
    else $error("beat did not advance through read and difference steps");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the final step");

  a_fin_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && out_stall) |=> (state_r == ST_FIN))
    else $error("final step left while output still stalled");

  a_ring_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && cnt_r == RUN_LAST) |-> !shift_en && (state_nxt == ST_FIN))
    else $error("bin ring shifted past one revolution");
`endif

endmodule

`default_nettype wire
